[hw/rtl/tcce_pkg.sv]
`default_nettype none

package tcce_pkg;

	// Default grid geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Fixed payload widths
	localparam int CMD_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int RROW_W     = 5;
	localparam int RCOL_W     = 7;
	localparam int CELL_W     = 16;
	localparam int COLOR_W    = 8;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BACK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	// Character and color constants
	localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
	localparam logic [CHAR_W-1:0]  CH_RETURN   = 8'd13;
	localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;
	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd15;

	// Cell store operations requested by the controller
	localparam logic [2:0] OP_NONE       = 3'd0;
	localparam logic [2:0] OP_PUT        = 3'd1;
	localparam logic [2:0] OP_BLANK_CUR  = 3'd2;
	localparam logic [2:0] OP_FILL_RESET = 3'd3;
	localparam logic [2:0] OP_FILL_COLOR = 3'd4;
	localparam logic [2:0] OP_SCROLL     = 3'd5;
	localparam logic [2:0] OP_READ       = 3'd6;

	// Cursor operations
	localparam logic [2:0] CUR_HOLD    = 3'd0;
	localparam logic [2:0] CUR_HOME    = 3'd1;
	localparam logic [2:0] CUR_COL0    = 3'd2;
	localparam logic [2:0] CUR_NEXTLN  = 3'd3;
	localparam logic [2:0] CUR_ADVANCE = 3'd4;
	localparam logic [2:0] CUR_BACK    = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [CHAR_W-1:0] char_code;
		logic [RROW_W-1:0] read_row;
		logic [RCOL_W-1:0] read_col;
	} item_t;

	typedef struct packed {
		logic [RROW_W-1:0] cursor_row_out;
		logic [RCOL_W-1:0] cursor_col_out;
		logic [CELL_W-1:0] cell_value;
		logic              echo_valid;
		logic [CHAR_W-1:0] echo_byte;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic       latch_item;
		logic       cell_load;
		logic       emit;
		logic       cnt_clr;
		logic [2:0] mem_op;
		logic [2:0] cur_op;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             is_newline;
		logic             is_return;
		logic             col_last;
		logic             row_last;
		logic             at_origin;
		logic             in_range;
		logic             fill_last;
		logic             scroll_last;
	} dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/tcce_ram.sv]
`default_nettype none

module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tcce_ctrl.sv]
`default_nettype none

module tcce_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output      logic                  busy,
	input  wire tcce_pkg::dp_status_t  status,
	output      tcce_pkg::ctrl_cmd_t   cmd
);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_BSW    = 3'd3;
	localparam logic [2:0] S_RWAIT  = 3'd4;
	localparam logic [2:0] S_SCROLL = 3'd5;
	localparam logic [2:0] S_CLEAR  = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.mem_op     = tcce_pkg::OP_NONE;
		cmd.cur_op     = tcce_pkg::CUR_HOLD;
		case (state_q)
			S_INIT: begin
				cmd.mem_op = tcce_pkg::OP_FILL_RESET;
				if (status.fill_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch_item = 1'b1;
					state_d        = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.cnt_clr = 1'b1;
				case (status.command)
					tcce_pkg::CMD_PUT: begin
						if (status.is_newline) begin
							if (status.row_last) begin
								cmd.cur_op = tcce_pkg::CUR_COL0;
								state_d    = S_SCROLL;
							end else begin
								cmd.cur_op = tcce_pkg::CUR_NEXTLN;
								state_d    = S_DONE;
							end
						end else if (status.is_return) begin
							cmd.cur_op = tcce_pkg::CUR_COL0;
							state_d    = S_DONE;
						end else begin
							cmd.mem_op = tcce_pkg::OP_PUT;
							if (!status.col_last) begin
								cmd.cur_op = tcce_pkg::CUR_ADVANCE;
								state_d    = S_DONE;
							end else if (status.row_last) begin
								cmd.cur_op = tcce_pkg::CUR_COL0;
								state_d    = S_SCROLL;
							end else begin
								cmd.cur_op = tcce_pkg::CUR_NEXTLN;
								state_d    = S_DONE;
							end
						end
					end
					tcce_pkg::CMD_BACK: begin
						if (status.at_origin) begin
							state_d = S_DONE;
						end else begin
							cmd.cur_op = tcce_pkg::CUR_BACK;
							state_d    = S_BSW;
						end
					end
					tcce_pkg::CMD_CLEAR: begin
						cmd.cur_op = tcce_pkg::CUR_HOME;
						state_d    = S_CLEAR;
					end
					tcce_pkg::CMD_READ: begin
						if (status.in_range) begin
							cmd.mem_op = tcce_pkg::OP_READ;
							state_d    = S_RWAIT;
						end else begin
							state_d = S_DONE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_BSW: begin
				cmd.mem_op = tcce_pkg::OP_BLANK_CUR;
				state_d    = S_DONE;
			end
			S_RWAIT: begin
				cmd.cell_load = 1'b1;
				state_d       = S_DONE;
			end
			S_SCROLL: begin
				cmd.mem_op = tcce_pkg::OP_SCROLL;
				if (status.scroll_last) begin
					state_d = S_DONE;
				end
			end
			S_CLEAR: begin
				cmd.mem_op = tcce_pkg::OP_FILL_COLOR;
				if (status.fill_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tcce_dpath.sv]
`default_nettype none

module tcce_dpath #(
	parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire tcce_pkg::item_t                     item,
	input  wire logic                                cfg_valid,
	input  wire logic [tcce_pkg::COLOR_W-1:0]        cfg_data,
	input  wire tcce_pkg::ctrl_cmd_t                 cmd,
	output      tcce_pkg::dp_status_t                status,
	output      logic                                done,
	output      tcce_pkg::result_t                   result
);

	localparam int N      = ROWS * COLUMNS;
	localparam int COPY_N = (ROWS - 1) * COLUMNS;
	localparam int AW     = $clog2(N);
	localparam int CW     = $clog2(N + 1);
	localparam int RW     = $clog2(ROWS);
	localparam int CLW    = $clog2(COLUMNS);
	localparam int ROW_OW = tcce_pkg::RROW_W;
	localparam int COL_OW = tcce_pkg::RCOL_W;
	localparam int CELL_W = tcce_pkg::CELL_W;

	localparam logic [CELL_W-1:0] RESET_BLANK = {tcce_pkg::RESET_COLOR, tcce_pkg::CH_SPACE};

	tcce_pkg::item_t              item_q;
	logic [tcce_pkg::COLOR_W-1:0] color_q;
	logic [RW-1:0]                row_q;
	logic [CLW-1:0]               col_q;
	logic [CW-1:0]                cnt_q;
	logic [CELL_W-1:0]            cell_q;
	tcce_pkg::result_t            result_q;
	logic                         done_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [CELL_W-1:0] rdata;
	logic [AW-1:0]     cur_addr;
	logic [AW-1:0]     cell_addr;
	logic [CELL_W-1:0] blank;
	logic              sweeping;

	assign blank     = {color_q, tcce_pkg::CH_SPACE};
	assign cur_addr  = AW'(32'(row_q) * COLUMNS + 32'(col_q));
	assign cell_addr = AW'(32'(item_q.read_row) * COLUMNS + 32'(item_q.read_col));
	assign sweeping  = (cmd.mem_op == tcce_pkg::OP_FILL_RESET) ||
	                   (cmd.mem_op == tcce_pkg::OP_FILL_COLOR) ||
	                   (cmd.mem_op == tcce_pkg::OP_SCROLL);

	// Status toward the controller
	always_comb begin
		status.command     = item_q.command;
		status.is_newline  = (item_q.char_code == tcce_pkg::CH_NEWLINE);
		status.is_return   = (item_q.char_code == tcce_pkg::CH_RETURN);
		status.col_last    = (col_q == CLW'(COLUMNS - 1));
		status.row_last    = (row_q == RW'(ROWS - 1));
		status.at_origin   = (col_q == '0) && (row_q == '0);
		status.in_range    = (32'(item_q.read_row) < ROWS) && (32'(item_q.read_col) < COLUMNS);
		status.fill_last   = (32'(cnt_q) == N - 1);
		status.scroll_last = (32'(cnt_q) == N);
	end

	// Cell store port control
	always_comb begin
		we    = 1'b0;
		waddr = cur_addr;
		wdata = blank;
		re    = 1'b0;
		raddr = cell_addr;
		case (cmd.mem_op)
			tcce_pkg::OP_PUT: begin
				we    = 1'b1;
				wdata = {color_q, item_q.char_code};
			end
			tcce_pkg::OP_BLANK_CUR: begin
				we = 1'b1;
			end
			tcce_pkg::OP_FILL_RESET: begin
				we    = 1'b1;
				waddr = AW'(cnt_q);
				wdata = RESET_BLANK;
			end
			tcce_pkg::OP_FILL_COLOR: begin
				we    = 1'b1;
				waddr = AW'(cnt_q);
			end
			tcce_pkg::OP_SCROLL: begin
				// read one row ahead, write the word read last cycle one row up
				we    = (cnt_q != '0);
				waddr = AW'(32'(cnt_q) - 1);
				wdata = (32'(cnt_q) <= COPY_N) ? rdata : blank;
				re    = (32'(cnt_q) < COPY_N);
				raddr = AW'(32'(cnt_q) + COLUMNS);
			end
			tcce_pkg::OP_READ: begin
				re = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	tcce_ram #(
		.WIDTH (CELL_W),
		.DEPTH (N)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Command item and read data
	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			item_q <= item;
		end
		if (cmd.latch_item) begin
			cell_q <= '0;
		end else if (cmd.cell_load) begin
			cell_q <= rdata;
		end
	end

	// Color register, cursor and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tcce_pkg::RESET_COLOR;
			row_q   <= '0;
			col_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_valid) begin
				color_q <= cfg_data;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (sweeping) begin
				cnt_q <= cnt_q + CW'(1);
			end
			case (cmd.cur_op)
				tcce_pkg::CUR_HOME: begin
					row_q <= '0;
					col_q <= '0;
				end
				tcce_pkg::CUR_COL0: begin
					col_q <= '0;
				end
				tcce_pkg::CUR_NEXTLN: begin
					row_q <= row_q + RW'(1);
					col_q <= '0;
				end
				tcce_pkg::CUR_ADVANCE: begin
					col_q <= col_q + CLW'(1);
				end
				tcce_pkg::CUR_BACK: begin
					if (col_q == '0) begin
						row_q <= row_q - RW'(1);
						col_q <= CLW'(COLUMNS - 1);
					end else begin
						col_q <= col_q - CLW'(1);
					end
				end
				default: begin
					row_q <= row_q;
				end
			endcase
		end
	end

	// Result register and strobe
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.cursor_row_out <= ROW_OW'(row_q);
			result_q.cursor_col_out <= COL_OW'(col_q);
			result_q.cell_value     <= cell_q;
			result_q.echo_valid     <= (item_q.command == tcce_pkg::CMD_PUT);
			result_q.echo_byte      <= (item_q.command == tcce_pkg::CMD_PUT) ?
			                           item_q.char_code : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

[hw/rtl/text_cell_console_engine.sv]
`default_nettype none

// Text cell console: a ROWS x COLUMNS grid of 16-bit cells (character in the
// low byte, color in the high byte) with a cursor, driven one command at a time.
// Command channel: an item transfers on a rising edge with start high and busy
// low. Each command gives exactly one result on the result port, marked by a
// one-cycle done strobe; the receiver has no way to stall it.
// Config channel: cfg_valid/cfg_ready carries the text color byte; cfg_ready
// is always high. Change the color only while the block is idle.
// Controller states per command, in order, ahead of the registered done strobe:
//   put character, newline, carriage return: EXEC, DONE
//   backspace: EXEC, BSW, DONE; read cell: EXEC, RWAIT, DONE; EXEC, DONE for a
//   backspace at the origin or a read outside the grid
//   clear screen: EXEC, CLEAR (one cell written per cycle), DONE
//   put that scrolls: EXEC, SCROLL (one cell moved per cycle), DONE
// The single-port-write cell RAM sets the sweep lengths.
// After reset the block walks the whole store once, writing a white-on-black
// space to every cell (ROWS*COLUMNS cells, 2000 by default); busy stays high
// until that pass ends. The cursor resets to the top left corner and the
// color to 0x0F.
module text_cell_console_engine #(
	parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output      logic                         busy,
	input  wire tcce_pkg::item_t              item,
	input  wire logic                         cfg_valid,
	output      logic                         cfg_ready,
	input  wire logic [tcce_pkg::COLOR_W-1:0] cfg_data,
	output      logic                         done,
	output      tcce_pkg::result_t            result
);

	tcce_pkg::ctrl_cmd_t  cmd;
	tcce_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	tcce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	tcce_dpath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.done      (done),
		.result    (result)
	);

endmodule

`default_nettype wire
